>>> design/bli_pkg.sv
package bli_pkg;

    // Field widths
    localparam int LVL_W  = 7;
    localparam int CF_W   = 7;
    localparam int DF_W   = 2;
    localparam int CNT_W  = 8;
    localparam int TIME_W = 4;
    localparam int IDX_W  = 3;
    localparam int CODE_W = 4;
    localparam int LEV_W  = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 4;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ERR_EN = 3'd0,
        REG_BLINK  = 3'd1,
        REG_LONG   = 3'd2,
        REG_SHORT  = 3'd3,
        REG_PAUSE  = 3'd4
    } reg_index_t;

    // LED level bits
    localparam logic [LEV_W-1:0] LV_RED   = 6'h01;
    localparam logic [LEV_W-1:0] LV_GREEN = 6'h02;
    localparam logic [LEV_W-1:0] LV_B25   = 6'h04;
    localparam logic [LEV_W-1:0] LV_B50   = 6'h08;
    localparam logic [LEV_W-1:0] LV_B75   = 6'h10;
    localparam logic [LEV_W-1:0] LV_B100  = 6'h20;
    localparam logic [LEV_W-1:0] LV_BARS  = 6'h3C;

    // Charge level thresholds
    localparam logic [LVL_W-1:0] FULL_LEVEL = 7'd100;
    localparam logic [LVL_W-1:0] LEVEL_75   = 7'd75;
    localparam logic [LVL_W-1:0] LEVEL_50   = 7'd50;
    localparam logic [LVL_W-1:0] LEVEL_25   = 7'd25;

    // Error codes
    localparam logic [CODE_W-1:0] CODE_DIS_UVP = 4'd8;
    localparam logic [CODE_W-1:0] CODE_DIS_OCP = 4'd9;
    localparam logic [CODE_W-1:0] CODE_OTHER   = 4'hF;
    localparam logic [IDX_W-1:0]  CODE_BITS    = 3'd4;

    // Register reset values
    localparam logic              RST_ERR_EN = 1'b1;
    localparam logic [TIME_W-1:0] RST_BLINK  = 4'd5;
    localparam logic [TIME_W-1:0] RST_LONG   = 4'd6;
    localparam logic [TIME_W-1:0] RST_SHORT  = 4'd2;
    localparam logic [TIME_W-1:0] RST_PAUSE  = 4'd10;

    typedef struct packed {
        logic              err_en;
        logic [TIME_W-1:0] blink_period;
        logic [TIME_W-1:0] long_pulse;
        logic [TIME_W-1:0] short_pulse;
        logic [TIME_W-1:0] pause;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] blink_count;
        logic [CNT_W-1:0]  display_left;
        logic [TIME_W-1:0] pulse_count;
        logic [IDX_W-1:0]  code_bit_index;
        logic [LEV_W-1:0]  led_levels;
    } state_t;

    typedef struct packed {
        logic [LVL_W-1:0] charge_level;
        logic             charging;
        logic             lamp_switch;
        logic [CF_W-1:0]  charge_faults;
        logic [DF_W-1:0]  discharge_faults;
        logic             other_fault;
        logic             display_load;
        logic [CNT_W-1:0] display_count;
    } tick_t;

    typedef struct packed {
        logic lamp_led;
        logic red_led;
        logic green_led;
        logic bar_25;
        logic bar_50;
        logic bar_75;
        logic bar_100;
    } leds_t;

endpackage

>>> design/bli_tick_if.sv
interface bli_tick_if;
    logic                        valid;
    logic                        ready;
    logic [bli_pkg::LVL_W-1:0]   charge_level;
    logic                        charging;
    logic                        lamp_switch;
    logic [bli_pkg::CF_W-1:0]    charge_faults;
    logic [bli_pkg::DF_W-1:0]    discharge_faults;
    logic                        other_fault;
    logic                        display_load;
    logic [bli_pkg::CNT_W-1:0]   display_count;

    modport source (
        output valid, charge_level, charging, lamp_switch, charge_faults,
               discharge_faults, other_fault, display_load, display_count,
        input  ready
    );
    modport sink (
        input  valid, charge_level, charging, lamp_switch, charge_faults,
               discharge_faults, other_fault, display_load, display_count,
        output ready
    );
endinterface

>>> design/bli_led_if.sv
interface bli_led_if;
    logic valid;
    logic ready;
    logic lamp_led;
    logic red_led;
    logic green_led;
    logic bar_25;
    logic bar_50;
    logic bar_75;
    logic bar_100;

    modport source (
        output valid, lamp_led, red_led, green_led, bar_25, bar_50, bar_75, bar_100,
        input  ready
    );
    modport sink (
        input  valid, lamp_led, red_led, green_led, bar_25, bar_50, bar_75, bar_100,
        output ready
    );
endinterface

>>> design/bli_cfg_regs.sv
module bli_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bli_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bli_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output bli_pkg::cfg_t                     cfg
);

    bli_pkg::cfg_t cfg_reg;

    // Register file, written one register per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.err_en       <= bli_pkg::RST_ERR_EN;
            cfg_reg.blink_period <= bli_pkg::RST_BLINK;
            cfg_reg.long_pulse   <= bli_pkg::RST_LONG;
            cfg_reg.short_pulse  <= bli_pkg::RST_SHORT;
            cfg_reg.pause        <= bli_pkg::RST_PAUSE;
        end
        else if (cfg_we)
        begin
            case (bli_pkg::reg_index_t'(cfg_index))
                bli_pkg::REG_ERR_EN: cfg_reg.err_en       <= cfg_wdata[0];
                bli_pkg::REG_BLINK:  cfg_reg.blink_period <= cfg_wdata;
                bli_pkg::REG_LONG:   cfg_reg.long_pulse   <= cfg_wdata;
                bli_pkg::REG_SHORT:  cfg_reg.short_pulse  <= cfg_wdata;
                bli_pkg::REG_PAUSE:  cfg_reg.pause        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/bli_tick_logic.sv
module bli_tick_logic (
    input  bli_pkg::cfg_t   cfg,
    input  bli_pkg::state_t state,
    input  bli_pkg::tick_t  tick,
    output bli_pkg::state_t state_next,
    output bli_pkg::leds_t  leds
);

    logic [bli_pkg::TIME_W:0]     blink_inc;
    logic [bli_pkg::TIME_W-1:0]   blink_new;
    logic [bli_pkg::CNT_W-1:0]    disp_left;
    logic                         fault_any;
    logic [bli_pkg::CODE_W-1:0]   err_code;
    logic [bli_pkg::TIME_W:0]     pause_inc;
    logic [bli_pkg::LEV_W-1:0]    lev;
    logic [bli_pkg::LEV_W-1:0]    chg_lev;
    logic [bli_pkg::LEV_W-1:0]    dis_lev;

    // Blink period counter
    always_comb
    begin
        blink_inc = {1'b0, state.blink_count} + 5'd1;
        if (blink_inc >= {1'b0, cfg.blink_period})
            blink_new = '0;
        else
            blink_new = blink_inc[bli_pkg::TIME_W-1:0];
    end

    // Priority encoder for the fault code, bit 0 of the charge faults first
    always_comb
    begin
        if (tick.discharge_faults[0])
            err_code = bli_pkg::CODE_DIS_UVP;
        else if (tick.discharge_faults[1])
            err_code = bli_pkg::CODE_DIS_OCP;
        else
            err_code = bli_pkg::CODE_OTHER;
        for (int b = bli_pkg::CF_W - 1; b >= 0; b--)
        begin
            if (tick.charge_faults[b])
                err_code = bli_pkg::CODE_W'(b + 1);
        end
    end

    assign fault_any = (tick.charge_faults != '0) || (tick.discharge_faults != '0)
                       || tick.other_fault;
    assign disp_left = tick.display_load ? tick.display_count : state.display_left;
    assign pause_inc = {1'b0, state.pulse_count} + 5'd1;
    assign lev       = state.led_levels;

    // Charging bar: top lit segment toggles on each update below full level; full level lights all bars and green
    always_comb
    begin
        if (tick.charge_level == bli_pkg::FULL_LEVEL)
            chg_lev = bli_pkg::LV_BARS | bli_pkg::LV_GREEN;
        else if (tick.charge_level >= bli_pkg::LEVEL_75)
            chg_lev = (lev & bli_pkg::LV_B100) ^ (bli_pkg::LV_B100 | bli_pkg::LV_B75
                      | bli_pkg::LV_B50 | bli_pkg::LV_B25 | bli_pkg::LV_RED);
        else if (tick.charge_level >= bli_pkg::LEVEL_50)
            chg_lev = (lev & bli_pkg::LV_B75) ^ (bli_pkg::LV_B75 | bli_pkg::LV_B50
                      | bli_pkg::LV_B25 | bli_pkg::LV_RED);
        else if (tick.charge_level >= bli_pkg::LEVEL_25)
            chg_lev = (lev & bli_pkg::LV_B50) ^ (bli_pkg::LV_B50 | bli_pkg::LV_B25
                      | bli_pkg::LV_RED);
        else
            chg_lev = (lev & bli_pkg::LV_B25) ^ (bli_pkg::LV_B25 | bli_pkg::LV_RED);
    end

    // Discharging bar: static
    always_comb
    begin
        if (tick.charge_level >= bli_pkg::LEVEL_75)
            dis_lev = bli_pkg::LV_BARS;
        else if (tick.charge_level >= bli_pkg::LEVEL_50)
            dis_lev = bli_pkg::LV_B25 | bli_pkg::LV_B50 | bli_pkg::LV_B75;
        else if (tick.charge_level >= bli_pkg::LEVEL_25)
            dis_lev = bli_pkg::LV_B25 | bli_pkg::LV_B50;
        else
            dis_lev = bli_pkg::LV_B25;
    end

    // Display mode selection and state update
    always_comb
    begin
        state_next              = state;
        state_next.blink_count  = blink_new;
        state_next.display_left = disp_left;

        if (fault_any && cfg.err_en)
        begin
            if (state.code_bit_index >= bli_pkg::CODE_BITS)
            begin
                // pause between code repeats
                state_next.led_levels = lev & ~bli_pkg::LV_RED;
                if (pause_inc >= {1'b0, cfg.pause})
                begin
                    state_next.pulse_count    = '0;
                    state_next.code_bit_index = '0;
                end
                else
                begin
                    state_next.pulse_count = pause_inc[bli_pkg::TIME_W-1:0];
                end
            end
            else if (state.pulse_count != '0)
            begin
                // pulse running
                state_next.pulse_count = state.pulse_count - 4'd1;
                if (state.pulse_count == 4'd1)
                begin
                    state_next.led_levels     = lev & ~bli_pkg::LV_RED;
                    state_next.code_bit_index = state.code_bit_index + 3'd1;
                end
            end
            else
            begin
                // start a pulse for the current code bit
                state_next.pulse_count = err_code[state.code_bit_index[1:0]]
                                         ? cfg.long_pulse : cfg.short_pulse;
                state_next.led_levels  = lev | bli_pkg::LV_RED;
            end
            state_next.led_levels = state_next.led_levels
                                    & ~(bli_pkg::LV_BARS | bli_pkg::LV_GREEN);
        end
        else if (tick.charging)
        begin
            if (blink_new == '0)
                state_next.led_levels = chg_lev;
        end
        else if (disp_left != '0)
        begin
            state_next.display_left = disp_left - 8'd1;
            state_next.led_levels   = dis_lev;
        end
        else
        begin
            state_next.led_levels = lev & ~bli_pkg::LV_BARS;
        end
    end

    // Result beat
    always_comb
    begin
        leds.lamp_led  = tick.lamp_switch;
        leds.red_led   = state_next.led_levels[0];
        leds.green_led = state_next.led_levels[1];
        leds.bar_25    = state_next.led_levels[2];
        leds.bar_50    = state_next.led_levels[3];
        leds.bar_75    = state_next.led_levels[4];
        leds.bar_100   = state_next.led_levels[5];
    end

endmodule

>>> design/battery_led_indicator.sv
// A tick beat is held in the input register, then in the output register.
// Throughput: one tick per cycle; the input register advances whenever the
// output register is empty or being taken, so stalls come only from led_out.ready.
// Reset (rst_n, async, active low): LED levels and counters zero, no beat held,
// registers at defaults (error display on, blink 5, long 6, short 2, pause 10).
module battery_led_indicator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bli_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bli_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    bli_tick_if.sink                          tick_in,
    bli_led_if.source                         led_out
);

    bli_pkg::cfg_t   cfg;
    bli_pkg::tick_t  in_data_reg;
    logic            in_valid_reg;
    bli_pkg::state_t state_reg;
    bli_pkg::state_t state_next;
    bli_pkg::leds_t  leds_next;
    bli_pkg::leds_t  out_data_reg;
    logic            out_valid_reg;
    logic            advance;
    logic            in_take;

    bli_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bli_tick_logic u_logic (
        .cfg        (cfg),
        .state      (state_reg),
        .tick       (in_data_reg),
        .state_next (state_next),
        .leds       (leds_next)
    );

    // Pipeline control
    assign advance       = in_valid_reg && (!out_valid_reg || led_out.ready);
    assign tick_in.ready = !in_valid_reg || advance;
    assign in_take       = tick_in.valid && tick_in.ready;

    // Input and output register valid and display state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (led_out.ready)
                out_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg.charge_level     <= tick_in.charge_level;
            in_data_reg.charging         <= tick_in.charging;
            in_data_reg.lamp_switch      <= tick_in.lamp_switch;
            in_data_reg.charge_faults    <= tick_in.charge_faults;
            in_data_reg.discharge_faults <= tick_in.discharge_faults;
            in_data_reg.other_fault      <= tick_in.other_fault;
            in_data_reg.display_load     <= tick_in.display_load;
            in_data_reg.display_count    <= tick_in.display_count;
        end
        if (advance)
            out_data_reg <= leds_next;
    end

    // Result beat
    assign led_out.valid     = out_valid_reg;
    assign led_out.lamp_led  = out_data_reg.lamp_led;
    assign led_out.red_led   = out_data_reg.red_led;
    assign led_out.green_led = out_data_reg.green_led;
    assign led_out.bar_25    = out_data_reg.bar_25;
    assign led_out.bar_50    = out_data_reg.bar_50;
    assign led_out.bar_75    = out_data_reg.bar_75;
    assign led_out.bar_100   = out_data_reg.bar_100;

endmodule

>>> test/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bli_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    typedef enum int {SEQ_FAULT, SEQ_CHARGE, SEQ_DISCHARGE, SEQ_NOISE} seq_kind_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    bli_tick_if tick_bus ();
    bli_led_if  led_bus ();

    battery_led_indicator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .tick_in   (tick_bus),
        .led_out   (led_bus)
    );

    // Shadow of the indicator: register file and per-tick state
    cfg_t              cfg_model  = '{RST_ERR_EN, RST_BLINK, RST_LONG, RST_SHORT, RST_PAUSE};
    logic [TIME_W-1:0] blink_cnt  = '0;
    logic [CNT_W-1:0]  disp_left  = '0;
    logic [TIME_W-1:0] pulse_cnt  = '0;
    logic [IDX_W-1:0]  bit_idx    = '0;
    logic [LEV_W-1:0]  levels     = '0;

    leds_t       expected_leds [$];
    int unsigned ticks_sent = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    bit          pace_on = 1'b1;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the shadow state by one display tick, return the LED beat it yields
    function automatic leds_t advance_display(input tick_t t);
        int unsigned       next_count;
        int                b;
        logic [CODE_W-1:0] code;
        logic [LEV_W-1:0]  lev;

        next_count = blink_cnt + 1;
        if (next_count >= cfg_model.blink_period)
            blink_cnt = '0;
        else
            blink_cnt = TIME_W'(next_count);

        if (t.display_load)
            disp_left = t.display_count;

        if ((t.charge_faults != '0 || t.discharge_faults != '0 || t.other_fault)
            && cfg_model.err_en)
        begin
            // lowest charge fault bit wins, then discharge faults, then catch-all
            code = CODE_OTHER;
            if (t.discharge_faults[1])
                code = CODE_DIS_OCP;
            if (t.discharge_faults[0])
                code = CODE_DIS_UVP;
            for (b = CF_W - 1; b >= 0; b--)
                if (t.charge_faults[b])
                    code = CODE_W'(b + 1);

            if (bit_idx >= CODE_BITS)
            begin
                // dark pause after the four code bits
                levels &= ~LV_RED;
                next_count = pulse_cnt + 1;
                if (next_count >= cfg_model.pause)
                begin
                    pulse_cnt = '0;
                    bit_idx   = '0;
                end
                else
                    pulse_cnt = TIME_W'(next_count);
            end
            else if (pulse_cnt != '0)
            begin
                pulse_cnt = pulse_cnt - 1'b1;
                if (pulse_cnt == '0)
                begin
                    levels &= ~LV_RED;
                    bit_idx = bit_idx + 1'b1;
                end
            end
            else
            begin
                pulse_cnt = code[bit_idx[1:0]] ? cfg_model.long_pulse : cfg_model.short_pulse;
                levels |= LV_RED;
            end
            levels &= ~(LV_BARS | LV_GREEN);
        end
        else if (t.charging)
        begin
            // bar refreshes only when the blink counter wraps; top segment toggles
            if (blink_cnt == '0)
            begin
                if (t.charge_level == FULL_LEVEL)
                    levels = LV_BARS | LV_GREEN;
                else
                begin
                    lev = (levels & ~LV_GREEN) | LV_RED;
                    if (t.charge_level >= LEVEL_75)
                        lev = (lev & LV_B100) ^ (LV_BARS | LV_RED);
                    else if (t.charge_level >= LEVEL_50)
                        lev = (lev & LV_B75) ^ (LV_B75 | LV_B50 | LV_B25 | LV_RED);
                    else if (t.charge_level >= LEVEL_25)
                        lev = (lev & LV_B50) ^ (LV_B50 | LV_B25 | LV_RED);
                    else
                        lev = (lev & LV_B25) ^ (LV_B25 | LV_RED);
                    levels = lev;
                end
            end
        end
        else if (disp_left != '0)
        begin
            disp_left = disp_left - 1'b1;
            if (t.charge_level >= LEVEL_75)
                levels = LV_BARS;
            else if (t.charge_level >= LEVEL_50)
                levels = LV_B25 | LV_B50 | LV_B75;
            else if (t.charge_level >= LEVEL_25)
                levels = LV_B25 | LV_B50;
            else
                levels = LV_B25;
        end
        else
            levels &= ~LV_BARS;

        return {t.lamp_switch, levels[0], levels[1], levels[2], levels[3], levels[4],
                levels[5]};
    endfunction

    // Idle length for either side: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (!pace_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tick_t make_tick(input logic [LVL_W-1:0] lvl, input logic chg,
                                        input logic lamp, input logic [CF_W-1:0] cf,
                                        input logic [DF_W-1:0] df, input logic other,
                                        input logic load, input logic [CNT_W-1:0] cnt);
        return {lvl, chg, lamp, cf, df, other, load, cnt};
    endfunction

    // Offer one tick beat, wait for it to be taken, record the expected LEDs
    task automatic send_tick(input tick_t t);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_bus.valid            <= 1'b1;
        tick_bus.charge_level     <= t.charge_level;
        tick_bus.charging         <= t.charging;
        tick_bus.lamp_switch      <= t.lamp_switch;
        tick_bus.charge_faults    <= t.charge_faults;
        tick_bus.discharge_faults <= t.discharge_faults;
        tick_bus.other_fault      <= t.other_fault;
        tick_bus.display_load     <= t.display_load;
        tick_bus.display_count    <= t.display_count;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
        expected_leds.push_back(advance_display(t));
        ticks_sent++;
    endtask

    // Stop offering ticks and wait for every outstanding LED beat
    task automatic drain();
        tick_bus.valid <= 1'b0;
        while (expected_leds.size() != 0)
            @(posedge clk);
    endtask

    // Write all five registers while the block is idle
    task automatic configure(input logic en, input logic [TIME_W-1:0] bp,
                             input logic [TIME_W-1:0] lp, input logic [TIME_W-1:0] sp,
                             input logic [TIME_W-1:0] ps);
        reg_index_t            order [5];
        logic [CFG_DATA_W-1:0] vals  [5];
        drain();
        order = '{REG_ERR_EN, REG_BLINK, REG_LONG, REG_SHORT, REG_PAUSE};
        // upper bits of the enable write are don't-care
        vals  = '{{3'($urandom_range(0, 7)), en}, bp, lp, sp, ps};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg_model.err_en       = en;
        cfg_model.blink_period = bp;
        cfg_model.long_pulse   = lp;
        cfg_model.short_pulse  = sp;
        cfg_model.pause        = ps;
    endtask

    // One well-formed run of ticks of the given kind, random content
    task automatic play_sequence(input seq_kind_t kind);
        tick_t            t;
        int unsigned      len;
        int unsigned      pick;
        logic [CF_W-1:0]  cf;
        logic [DF_W-1:0]  df;
        logic             other;
        logic [LVL_W-1:0] lvl;

        // fault pattern held for the whole run
        cf    = '0;
        df    = '0;
        other = 1'b0;
        pick  = $urandom_range(0, 99);
        if (pick < 40)
            cf = (CF_W'($urandom) | CF_W'(1)) << $urandom_range(0, CF_W - 1);
        else if (pick < 60)
            df = DF_W'($urandom_range(1, 3));
        else if (pick < 75)
            other = 1'b1;
        else
        begin
            cf    = CF_W'($urandom);
            df    = DF_W'($urandom);
            other = 1'b1;
        end

        pick = $urandom_range(0, 99);
        if (pick < 15)
            lvl = FULL_LEVEL;
        else if (pick < 25)
            lvl = LVL_W'($urandom_range(101, 127));
        else
            lvl = LVL_W'($urandom_range(0, 99));

        case (kind)
            SEQ_FAULT: len = $urandom_range(10, 50);
            SEQ_NOISE: len = $urandom_range(1, 8);
            default:   len = $urandom_range(5, 20);
        endcase

        for (int i = 0; i < len; i++)
        begin
            t.charge_level     = lvl;
            t.charging         = 1'($urandom);
            t.lamp_switch      = 1'($urandom);
            t.charge_faults    = '0;
            t.discharge_faults = '0;
            t.other_fault      = 1'b0;
            t.display_load     = ($urandom_range(0, 15) == 0);
            t.display_count    = CNT_W'($urandom);
            case (kind)
                SEQ_FAULT:
                begin
                    t.charge_faults    = cf;
                    t.discharge_faults = df;
                    t.other_fault      = other;
                end
                SEQ_CHARGE:
                begin
                    t.charging = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        lvl = LVL_W'($urandom_range(0, 100));
                end
                SEQ_DISCHARGE:
                begin
                    t.charging      = 1'b0;
                    t.display_count = CNT_W'($urandom_range(0, 40));
                    if (i == 0)
                    begin
                        t.display_load = 1'b1;
                        if ($urandom_range(0, 7) == 0)
                            t.display_count = '1;
                    end
                end
                default:
                begin
                    t.charge_level     = LVL_W'($urandom);
                    t.display_load     = 1'($urandom);
                    t.charge_faults    = ($urandom_range(0, 2) == 0) ? CF_W'($urandom) : '0;
                    t.discharge_faults = ($urandom_range(0, 2) == 0) ? DF_W'($urandom) : '0;
                    t.other_fault      = ($urandom_range(0, 2) == 0);
                end
            endcase
            send_tick(t);
        end
    endtask

    // Reset defaults, discharge countdown bar, charge bar at the level boundaries
    task automatic test_display_modes();
        send_tick(make_tick(7'd0, 1'b0, 1'b1, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd100, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
        configure(1'b1, 4'd1, 4'd6, 4'd2, 4'd10);
        // discharge: long countdown, bar follows level
        send_tick(make_tick(7'd0, 1'b0, 1'b1, '0, '0, 1'b0, 1'b1, 8'd255));
        send_tick(make_tick(7'd25, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd50, 1'b0, 1'b1, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd75, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd127, 1'b0, 1'b1, '0, '0, 1'b0, 1'b0, 8'd0));
        // countdown of one runs out, then the bar goes dark
        send_tick(make_tick(7'd60, 1'b0, 1'b0, '0, '0, 1'b0, 1'b1, 8'd1));
        send_tick(make_tick(7'd60, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
        // charging: every tick refreshes, top segment toggles
        send_tick(make_tick(7'd24, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd49, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd74, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd99, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd100, 1'b1, 1'b1, '0, '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd127, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 8'd0));
    endtask

    // Each fault source once, then faults with the error display off
    task automatic test_error_codes();
        configure(1'b1, 4'd5, 4'd1, 4'd1, 4'd1);
        for (int b = 0; b < CF_W; b++)
            send_tick(make_tick(7'd80, 1'b1, 1'b1, CF_W'(1 << b), '0, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd80, 1'b0, 1'b0, '0, 2'd1, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd80, 1'b0, 1'b1, '0, 2'd2, 1'b0, 1'b0, 8'd0));
        send_tick(make_tick(7'd80, 1'b1, 1'b0, '0, '0, 1'b1, 1'b0, 8'd0));
        send_tick(make_tick(7'd80, 1'b1, 1'b1, '1, '1, 1'b1, 1'b1, 8'd3));
        configure(1'b0, 4'd1, 4'd1, 4'd1, 4'd1);
        send_tick(make_tick(7'd30, 1'b1, 1'b0, '1, '1, 1'b1, 1'b0, 8'd0));
    endtask

    // Register extremes, zero timings, and counters left above a lowered period
    task automatic test_config_extremes();
        logic [4*TIME_W:0] settings [6];
        settings = '{{1'b0, 4'd15, 4'd15, 4'd15, 4'd15},
                     {1'b1, 4'd1, 4'd1, 4'd1, 4'd1},
                     {1'b1, 4'd15, 4'd15, 4'd15, 4'd15},
                     {1'b1, 4'd2, 4'd3, 4'd1, 4'd2},
                     {1'b1, 4'd0, 4'd0, 4'd0, 4'd0},
                     {RST_ERR_EN, RST_BLINK, RST_LONG, RST_SHORT, RST_PAUSE}};
        foreach (settings[i])
        begin
            configure(settings[i][16], settings[i][15:12], settings[i][11:8],
                      settings[i][7:4], settings[i][3:0]);
            play_sequence(SEQ_FAULT);
            play_sequence(SEQ_CHARGE);
            play_sequence(SEQ_DISCHARGE);
            play_sequence(SEQ_NOISE);
        end
    endtask

    // Random settings and mostly well-formed runs, some stretches at full rate
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned pick;
        goal = ticks_sent + 60;
        while (ticks_sent < goal)
        begin
            configure($urandom_range(0, 3) != 0, TIME_W'($urandom_range(1, 15)),
                      TIME_W'($urandom_range(1, 15)), TIME_W'($urandom_range(1, 15)),
                      TIME_W'($urandom_range(1, 15)));
            pace_on = ($urandom_range(0, 3) != 0);
            repeat (4)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    play_sequence(SEQ_FAULT);
                else if (pick < 60)
                    play_sequence(SEQ_CHARGE);
                else if (pick < 85)
                    play_sequence(SEQ_DISCHARGE);
                else
                    play_sequence(SEQ_NOISE);
            end
        end
        pace_on = 1'b1;
    endtask

    // LED sink pacing
    initial
    begin : led_pacing
        int unsigned stall;
        led_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_len();
            if (stall != 0)
            begin
                led_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            led_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Compare each LED beat with the oldest expectation
    always @(posedge clk)
    begin : led_check
        leds_t seen;
        leds_t want;
        if (rst_n && led_bus.valid && led_bus.ready)
        begin
            seen = {led_bus.lamp_led, led_bus.red_led, led_bus.green_led, led_bus.bar_25,
                    led_bus.bar_50, led_bus.bar_75, led_bus.bar_100};
            if (expected_leds.size() == 0)
            begin
                $display("%0t: LED beat %b with nothing expected", $time, seen);
                mismatches++;
            end
            else
            begin
                want = expected_leds.pop_front();
                if (seen !== want)
                begin
                    $display("%0t: LED mismatch (lamp red green bar25..bar100) exp %b act %b",
                             $time, want, seen);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any beat taken on either side
    always @(posedge clk)
    begin
        if (!rst_n || (tick_bus.valid && tick_bus.ready) || (led_bus.valid && led_bus.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= '0;
        cfg_wdata                 <= '0;
        tick_bus.valid            <= 1'b0;
        tick_bus.charge_level     <= '0;
        tick_bus.charging         <= 1'b0;
        tick_bus.lamp_switch      <= 1'b0;
        tick_bus.charge_faults    <= '0;
        tick_bus.discharge_faults <= '0;
        tick_bus.other_fault      <= 1'b0;
        tick_bus.display_load     <= 1'b0;
        tick_bus.display_count    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_display_modes();
        test_error_codes();
        test_config_extremes();
        test_random_traffic();

        drain();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_leds.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
